@@ rtl/scld_pkg.sv @@
// package for the serial command line decoder
// holds event codes, mode codes, command letters, character constants and size defaults
package scld_pkg;

   localparam int LINE_BUFFER_BYTES_DEF = 12;
   localparam logic [9:0] NUM_SAT = 10'd1023;

   localparam logic [3:0] EV_STAND     = 4'd0;
   localparam logic [3:0] EV_TROT      = 4'd1;
   localparam logic [3:0] EV_STEP      = 4'd2;
   localparam logic [3:0] EV_HIGH      = 4'd3;
   localparam logic [3:0] EV_LOW       = 4'd4;
   localparam logic [3:0] EV_SHIFT     = 4'd5;
   localparam logic [3:0] EV_ROLL      = 4'd6;
   localparam logic [3:0] EV_STOPALL   = 4'd7;
   localparam logic [3:0] EV_MOTORSTOP = 4'd8;
   localparam logic [3:0] EV_MOTORSET  = 4'd9;
   localparam logic [3:0] EV_APPLY     = 4'd10;
   localparam logic [3:0] EV_CANCEL    = 4'd11;
   localparam logic [3:0] EV_PENDING   = 4'd12;
   localparam logic [3:0] EV_SELECT    = 4'd13;
   localparam logic [3:0] EV_UNKNOWN   = 4'd14;

   localparam logic [1:0] CTL_CALIBRATE = 2'd0;
   localparam logic [1:0] CTL_STANDING  = 2'd1;
   localparam logic [1:0] CTL_TROTTING  = 2'd2;
   localparam logic [1:0] CTL_STEPPING  = 2'd3;

   // command letters, upper case
   localparam logic [7:0] CMD_STAND = 8'h47;
   localparam logic [7:0] CMD_TROT  = 8'h54;
   localparam logic [7:0] CMD_STEP  = 8'h41;
   localparam logic [7:0] CMD_HIGH  = 8'h48;
   localparam logic [7:0] CMD_LOW   = 8'h4C;
   localparam logic [7:0] CMD_SHIFT = 8'h58;
   localparam logic [7:0] CMD_ROLL  = 8'h52;
   localparam logic [7:0] CMD_STOP  = 8'h53;
   localparam logic [7:0] CMD_MOTOR = 8'h4D;
   localparam logic [7:0] CMD_YES   = 8'h59;
   localparam logic [7:0] CMD_NO    = 8'h4E;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_MINUS = 8'h2D;

   // digit accumulator request
   typedef struct packed {
      logic [9:0] acc;
      logic [7:0] ch;
   } acc_req_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      if ((c >= 8'h61) && (c <= 8'h7A)) return c - 8'd32;
      return c;
   endfunction

endpackage

@@ rtl/scld_digit_acc.sv @@
// shared digit accumulator: acc*10 + digit, saturating at 1023
// depends on scld_pkg
module scld_digit_acc (
   input  scld_pkg::acc_req_type req,
   output logic [9:0]            acc_out
);
   logic [14:0] sum;

   // times ten as shift and add, then saturate
   always_comb begin
      sum = {2'b00, req.acc, 3'b000} + {4'b0000, req.acc, 1'b0}
            + {11'd0, req.ch[3:0]};
      acc_out = (sum > {5'd0, scld_pkg::NUM_SAT}) ? scld_pkg::NUM_SAT : sum[9:0];
   end
endmodule

@@ rtl/serial_command_line_decoder_core.sv @@
// top level of the serial command line decoder
// depends on scld_pkg and scld_digit_acc
//
// Bytes are buffered only while the sequencer is idle; req_stall is high
// otherwise. A CR or LF after a non-empty line starts a sequencer that
// walks the buffered characters one at a time through a shared digit
// accumulator; the result then waits in an output register until taken.
// No reset clearing pass is needed.
module serial_command_line_decoder_core #(
   parameter int LINE_BUFFER_BYTES = scld_pkg::LINE_BUFFER_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [3:0]        rsp_event_res,
   output logic [1:0]        rsp_mode,
   output logic [1:0]        rsp_step_phase,
   output logic [1:0]        rsp_motor_index,
   output logic [6:0]        rsp_motor_speed,
   output logic              rsp_motor_forward,
   output logic [3:0]        rsp_servo_number,
   output logic [8:0]        rsp_servo_angle,
   output logic signed [6:0] rsp_foot_shift,
   output logic [7:0]        rsp_first_char
);
   localparam int MAXC = LINE_BUFFER_BYTES - 1;
   localparam int LW = $clog2(LINE_BUFFER_BYTES + 1);
   localparam int AW = $clog2(LINE_BUFFER_BYTES);

   typedef enum logic [2:0] {
      ST_IDLE, ST_NUM1, ST_SKIP, ST_NUM2, ST_SKIP2, ST_NUM3, ST_DONE, ST_OUT
   } state_type;

   state_type   state_ff;
   logic [7:0]  line_ff [LINE_BUFFER_BYTES];
   logic [LW-1:0] len_ff, pos_ff;
   logic [9:0]  n1_ff, n2_ff, n3_ff;
   logic        neg_ff, has3_ff;
   logic [1:0]  mode_ff, phase_ff;
   logic [3:0]  sel_ff, pserv_ff;
   logic        pflag_ff;
   logic [8:0]  pang_ff;

   logic [3:0] ev_ff;
   logic [1:0] mi_ff;
   logic [6:0] ms_ff;
   logic       mf_ff;
   logic [3:0] sn_ff;
   logic [8:0] sa_ff;
   logic [6:0] fs_ff;
   logic [7:0] fc_ff;

   logic [7:0] cur, f, u;
   scld_pkg::acc_req_type areq;
   logic [9:0] acc_in;

   // character at the walk position, zero past the line end
   always_comb begin
      cur = (pos_ff < len_ff) ? line_ff[pos_ff[AW-1:0]] : 8'd0;
      f = line_ff[0];
      u = scld_pkg::to_upper(f);
      areq.ch = cur;
      case (state_ff)
         ST_NUM2: areq.acc = n2_ff;
         ST_NUM3: areq.acc = n3_ff;
         default: areq.acc = n1_ff;
      endcase
   end

   scld_digit_acc u_acc (.req(areq), .acc_out(acc_in));

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_event_res = ev_ff;
   assign rsp_mode = mode_ff;
   assign rsp_step_phase = phase_ff;
   assign rsp_motor_index = mi_ff;
   assign rsp_motor_speed = ms_ff;
   assign rsp_motor_forward = mf_ff;
   assign rsp_servo_number = sn_ff;
   assign rsp_servo_angle = sa_ff;
   assign rsp_foot_shift = fs_ff;
   assign rsp_first_char = fc_ff;

   // line buffer, sequencer and control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff <= '0;
         mode_ff <= scld_pkg::CTL_CALIBRATE;
         phase_ff <= 2'd0;
         sel_ff <= 4'd1;
         pflag_ff <= 1'b0;
         pserv_ff <= 4'd0;
         pang_ff <= 9'd0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  if (req_rx_byte == scld_pkg::CH_CR || req_rx_byte == scld_pkg::CH_LF) begin
                     if (len_ff != '0) begin
                        n1_ff <= '0; n2_ff <= '0; n3_ff <= '0;
                        neg_ff <= 1'b0; has3_ff <= 1'b0;
                        // numeric lines start at 0, letter lines at 1
                        pos_ff <= scld_pkg::is_digit(line_ff[0]) ? LW'(0) : LW'(1);
                        state_ff <= ST_NUM1;
                        if (scld_pkg::to_upper(line_ff[0]) == scld_pkg::CMD_SHIFT)
                           state_ff <= ST_SKIP;
                     end
                  end else if (scld_pkg::is_digit(req_rx_byte)
                               || req_rx_byte == scld_pkg::CH_COLON
                               || req_rx_byte == scld_pkg::CH_MINUS) begin
                     if (len_ff < LW'(MAXC)) begin
                        line_ff[len_ff[AW-1:0]] <= req_rx_byte;
                        len_ff <= len_ff + 1'b1;
                     end
                  end else if (scld_pkg::is_letter(req_rx_byte) && len_ff == '0) begin
                     line_ff[0] <= req_rx_byte;
                     len_ff <= LW'(1);
                  end
               end
            end
            // x command: optional colon then optional minus
            ST_SKIP: begin
               if (cur == scld_pkg::CH_COLON && !has3_ff) begin
                  pos_ff <= pos_ff + 1'b1;
                  has3_ff <= 1'b1;
               end else begin
                  if (cur == scld_pkg::CH_MINUS) begin
                     neg_ff <= 1'b1;
                     pos_ff <= pos_ff + 1'b1;
                  end
                  state_ff <= ST_NUM1;
               end
            end
            ST_NUM1: begin
               if (scld_pkg::is_digit(cur)) begin
                  n1_ff <= acc_in;
                  pos_ff <= pos_ff + 1'b1;
               end else if (scld_pkg::is_digit(f)) begin
                  // servo line: second number after the first colon
                  if (cur == scld_pkg::CH_COLON) begin
                     has3_ff <= 1'b1;
                     pos_ff <= pos_ff + 1'b1;
                     state_ff <= ST_NUM2;
                  end else if (pos_ff < len_ff) begin
                     pos_ff <= pos_ff + 1'b1;
                     state_ff <= ST_SKIP2;
                  end else state_ff <= ST_DONE;
               end else if (u == scld_pkg::CMD_MOTOR) begin
                  if (cur == scld_pkg::CH_COLON) pos_ff <= pos_ff + 1'b1;
                  state_ff <= ST_NUM2;
               end else state_ff <= ST_DONE;
            end
            // servo line: hunt for the first colon
            ST_SKIP2: begin
               if (cur == scld_pkg::CH_COLON) begin
                  has3_ff <= 1'b1;
                  pos_ff <= pos_ff + 1'b1;
                  state_ff <= ST_NUM2;
               end else if (pos_ff < len_ff) pos_ff <= pos_ff + 1'b1;
               else state_ff <= ST_DONE;
            end
            ST_NUM2: begin
               if (scld_pkg::is_digit(cur)) begin
                  n2_ff <= acc_in;
                  pos_ff <= pos_ff + 1'b1;
               end else if (u == scld_pkg::CMD_MOTOR && cur == scld_pkg::CH_COLON) begin
                  has3_ff <= 1'b1;
                  pos_ff <= pos_ff + 1'b1;
                  state_ff <= ST_NUM3;
               end else state_ff <= ST_DONE;
            end
            ST_NUM3: begin
               if (scld_pkg::is_digit(cur)) begin
                  n3_ff <= acc_in;
                  pos_ff <= pos_ff + 1'b1;
               end else state_ff <= ST_DONE;
            end
            // decode the command and update control state
            ST_DONE: begin
               len_ff <= '0;
               state_ff <= ST_OUT;
               mi_ff <= 2'd0; ms_ff <= 7'd0; mf_ff <= 1'b0; sn_ff <= 4'd0;
               sa_ff <= 9'd0; fs_ff <= 7'd0; fc_ff <= 8'd0;
               case (u)
                  scld_pkg::CMD_STAND: begin
                     mode_ff <= scld_pkg::CTL_STANDING;
                     ev_ff <= scld_pkg::EV_STAND;
                  end
                  scld_pkg::CMD_TROT: begin
                     mode_ff <= scld_pkg::CTL_TROTTING;
                     ev_ff <= scld_pkg::EV_TROT;
                  end
                  scld_pkg::CMD_STEP: begin
                     if (mode_ff != scld_pkg::CTL_STEPPING) begin
                        mode_ff <= scld_pkg::CTL_STEPPING;
                        phase_ff <= 2'd0;
                     end else phase_ff <= phase_ff + 2'd1;
                     ev_ff <= scld_pkg::EV_STEP;
                  end
                  scld_pkg::CMD_HIGH: begin
                     mode_ff <= scld_pkg::CTL_STANDING;
                     ev_ff <= scld_pkg::EV_HIGH;
                  end
                  scld_pkg::CMD_LOW: begin
                     mode_ff <= scld_pkg::CTL_STANDING;
                     ev_ff <= scld_pkg::EV_LOW;
                  end
                  scld_pkg::CMD_SHIFT: begin
                     if (n1_ff <= 10'd60) begin
                        fs_ff <= neg_ff ? 7'(-n1_ff[6:0]) : n1_ff[6:0];
                        ev_ff <= scld_pkg::EV_SHIFT;
                     end else state_ff <= ST_IDLE;
                  end
                  scld_pkg::CMD_ROLL: ev_ff <= scld_pkg::EV_ROLL;
                  scld_pkg::CMD_STOP: ev_ff <= scld_pkg::EV_STOPALL;
                  scld_pkg::CMD_MOTOR: begin
                     if (n1_ff <= 10'd3 && n2_ff <= 10'd100) begin
                        mi_ff <= n1_ff[1:0];
                        if (n2_ff == 10'd0) ev_ff <= scld_pkg::EV_MOTORSTOP;
                        else begin
                           ms_ff <= n2_ff[6:0];
                           mf_ff <= !has3_ff || (n3_ff != 10'd0);
                           ev_ff <= scld_pkg::EV_MOTORSET;
                        end
                     end else state_ff <= ST_IDLE;
                  end
                  scld_pkg::CMD_YES: begin
                     if (pflag_ff && pserv_ff >= 4'd1 && pserv_ff <= 4'd12) begin
                        sel_ff <= pserv_ff;
                        pflag_ff <= 1'b0;
                        sn_ff <= pserv_ff;
                        sa_ff <= pang_ff;
                        ev_ff <= scld_pkg::EV_APPLY;
                     end else state_ff <= ST_IDLE;
                  end
                  scld_pkg::CMD_NO: begin
                     pflag_ff <= 1'b0;
                     ev_ff <= scld_pkg::EV_CANCEL;
                  end
                  default: begin
                     if (scld_pkg::is_digit(f)) begin
                        if (has3_ff) begin
                           if (n1_ff >= 10'd1 && n1_ff <= 10'd12 && n2_ff <= 10'd270) begin
                              pserv_ff <= n1_ff[3:0]; pang_ff <= n2_ff[8:0];
                              pflag_ff <= 1'b1;
                              sn_ff <= n1_ff[3:0]; sa_ff <= n2_ff[8:0];
                              ev_ff <= scld_pkg::EV_PENDING;
                           end else state_ff <= ST_IDLE;
                        end else if (n1_ff >= 10'd1 && n1_ff <= 10'd12) begin
                           sel_ff <= n1_ff[3:0]; pflag_ff <= 1'b0;
                           sn_ff <= n1_ff[3:0];
                           ev_ff <= scld_pkg::EV_SELECT;
                        end else if (n1_ff <= 10'd270) begin
                           pserv_ff <= sel_ff; pang_ff <= n1_ff[8:0];
                           pflag_ff <= 1'b1;
                           sn_ff <= sel_ff; sa_ff <= n1_ff[8:0];
                           ev_ff <= scld_pkg::EV_PENDING;
                        end else state_ff <= ST_IDLE;
                     end else begin
                        fc_ff <= f;
                        ev_ff <= scld_pkg::EV_UNKNOWN;
                     end
                  end
               endcase
            end
            ST_OUT: if (!rsp_stall) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

@@ rtl/scld_checker.sv @@
// port level checker for the serial command line decoder
// bound to serial_command_line_decoder_core, depends on scld_pkg
module scld_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [3:0] rsp_event_res,
   input logic [6:0] rsp_motor_speed,
   input logic [6:0] rsp_foot_shift
);
   // busy while a result waits
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("input taken while result waits");
   // result held while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_res))
      else $error("stalled result changed");
   // event code in range
   a_ev: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_event_res <= scld_pkg::EV_UNKNOWN) else $error("bad event code");
   // speed only on motor set
   a_spd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != scld_pkg::EV_MOTORSET |-> rsp_motor_speed == 7'd0)
      else $error("speed outside motor set");
   // shift only on shift event
   a_sh: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != scld_pkg::EV_SHIFT |-> rsp_foot_shift == 7'd0)
      else $error("shift outside shift event");
endmodule

bind serial_command_line_decoder_core scld_checker u_scld_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_event_res(rsp_event_res),
   .rsp_motor_speed(rsp_motor_speed), .rsp_foot_shift(rsp_foot_shift)
);
